FILE: design/rfidhex_pkg.sv
// Shared types and constants for the RFID ASCII hex frame parser.
// No dependencies; compiled first.
`default_nettype none

package rfidhex_pkg;

  localparam int BYTE_W        = 8;
  localparam int NIBBLE_W      = 4;
  localparam int TAG_BYTES     = 5;
  localparam int TAG_W         = TAG_BYTES * BYTE_W;
  localparam int FRAME_DIGITS  = 12;
  localparam int DIGIT_CNT_W   = 4;
  localparam int QUEUE_DEPTH   = 2;

  // Framing bytes
  localparam logic [BYTE_W-1:0] START_BYTE = 8'h02;
  localparam logic [BYTE_W-1:0] END_BYTE   = 8'h03;
  localparam logic [BYTE_W-1:0] CR_BYTE    = 8'h0D;
  localparam logic [BYTE_W-1:0] LF_BYTE    = 8'h0A;

  // ASCII digit ranges
  localparam logic [BYTE_W-1:0] ASCII_0 = 8'h30;
  localparam logic [BYTE_W-1:0] ASCII_9 = 8'h39;
  localparam logic [BYTE_W-1:0] ASCII_A = 8'h41;
  localparam logic [BYTE_W-1:0] ASCII_F = 8'h46;

  // Byte class handed from the front end to the frame assembler
  typedef enum logic [1:0] {
    TOK_START,
    TOK_ABORT,
    TOK_DIGIT
  } tok_kind_t;

  typedef struct packed {
    tok_kind_t         kind;
    logic [BYTE_W-1:0] value;  // converted digit value for TOK_DIGIT
  } token_t;

endpackage

`default_nettype wire

FILE: design/rfid_ascii_hex_frame_parser_unit.sv
// Top level of the RFID ASCII hex frame parser.
// Depends on rfidhex_pkg, rfidhex_front, rfidhex_queue and rfidhex_back.
`default_nettype none

// Parses the ASCII frames sent by ID-12 style RFID readers, one received
// byte per transfer. Idle bytes are ignored until a start byte (0x02) opens a
// frame. Inside a frame, 0x02, 0x03, CR or LF drop the frame with no result
// (0x02 does not reopen one). Other bytes are hex digits: '0'-'9' and 'A'-'F'
// convert to their value, any other byte (lowercase included) is used raw,
// and a digit pair forms (second | first << 4) cut to 8 bits. The first five
// bytes make the 40-bit tag code, first byte on top, and are XORed together;
// the sixth is the checksum. The twelfth digit produces one result transfer
// carrying tag_code, received_checksum and checksum_ok.
// Rate: one byte per clock, sustained, as long as results are taken, through
// the front register, the queue and the frame assembler. After the final
// digit's transfer the result passes the front register, then the queue, and
// is presented once it loads the output register. A stalled output holds the
// assembler, the queue absorbs the bytes in flight, and in_ready then drops.
module rfid_ascii_hex_frame_parser_unit #(
  parameter int QUEUE_DEPTH = rfidhex_pkg::QUEUE_DEPTH
) (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic [7:0]   rx_byte,
  input  wire logic         in_valid,
  output logic              in_ready,
  output logic [39:0]       tag_code,
  output logic [7:0]        received_checksum,
  output logic              checksum_ok,
  output logic              out_valid,
  input  wire logic         out_ready
);
  import rfidhex_pkg::*;

  // Front end to queue
  token_t front_tok;
  logic   front_valid;
  logic   front_ready;

  // Queue to frame assembler
  token_t back_tok;
  logic   back_valid;
  logic   back_ready;

  rfidhex_front u_front (
    .clk       (clk),
    .rst       (rst),
    .rx_byte   (rx_byte),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .tok       (front_tok),
    .tok_valid (front_valid),
    .tok_ready (front_ready)
  );

  rfidhex_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .in_data   (front_tok),
    .in_valid  (front_valid),
    .in_ready  (front_ready),
    .out_data  (back_tok),
    .out_valid (back_valid),
    .out_ready (back_ready)
  );

  rfidhex_back u_back (
    .clk               (clk),
    .rst               (rst),
    .tok               (back_tok),
    .tok_valid         (back_valid),
    .tok_ready         (back_ready),
    .tag_code          (tag_code),
    .received_checksum (received_checksum),
    .checksum_ok       (checksum_ok),
    .out_valid         (out_valid),
    .out_ready         (out_ready)
  );

endmodule

`default_nettype wire

FILE: design/rfidhex_front.sv
// Front end: accepts received bytes, classifies them and converts hex digits.
// Depends on rfidhex_pkg.
`default_nettype none

module rfidhex_front (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic [7:0]                rx_byte,
  input  wire logic                      in_valid,
  output logic                           in_ready,
  output rfidhex_pkg::token_t            tok,
  output logic                           tok_valid,
  input  wire logic                      tok_ready
);
  import rfidhex_pkg::*;

  token_t tok_next;

  // Start byte opens a frame (and aborts one in progress); the other
  // control bytes only abort. Everything else is a digit.
  always_comb begin
    tok_next.value = rx_byte;
    if (rx_byte == START_BYTE) begin
      tok_next.kind = TOK_START;
    end else if (rx_byte == END_BYTE || rx_byte == CR_BYTE || rx_byte == LF_BYTE) begin
      tok_next.kind = TOK_ABORT;
    end else begin
      tok_next.kind = TOK_DIGIT;
      if (rx_byte >= ASCII_0 && rx_byte <= ASCII_9) begin
        tok_next.value = rx_byte - ASCII_0;
      end else if (rx_byte >= ASCII_A && rx_byte <= ASCII_F) begin
        tok_next.value = rx_byte - ASCII_A + BYTE_W'(10);
      end
    end
  end

  assign in_ready = !tok_valid || tok_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      tok_valid <= 1'b0;
    end else if (in_ready) begin
      tok_valid <= in_valid;
      if (in_valid) begin
        tok <= tok_next;
      end
    end
  end

endmodule

`default_nettype wire

FILE: design/rfidhex_queue.sv
// Short token queue between the front end and the frame assembler.
// Depends on rfidhex_pkg.
`default_nettype none

module rfidhex_queue #(
  parameter int DEPTH = rfidhex_pkg::QUEUE_DEPTH
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  rfidhex_pkg::token_t       in_data,
  input  wire logic                 in_valid,
  output logic                      in_ready,
  output rfidhex_pkg::token_t       out_data,
  output logic                      out_valid,
  input  wire logic                 out_ready
);
  import rfidhex_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  token_t             entries [DEPTH];
  logic [PTR_W-1:0]   wr_ptr;
  logic [PTR_W-1:0]   rd_ptr;
  logic [CNT_W-1:0]   count;
  logic               push;
  logic               pop;

  assign in_ready  = (count != CNT_W'(DEPTH));
  assign out_valid = (count != '0);
  assign out_data  = entries[rd_ptr];
  assign push      = in_valid && in_ready;
  assign pop       = out_valid && out_ready;

  function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
    return (p == PTR_W'(DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= ptr_inc(wr_ptr);
      end
      if (pop) begin
        rd_ptr <= ptr_inc(rd_ptr);
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= in_data;
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(DEPTH))
    else $error("queue count above depth");

  a_count_up: assert property (@(posedge clk) disable iff (rst)
    push && !pop |=> count == CNT_W'($past(count) + 1'b1))
    else $error("queue count missed a push");

  a_count_down: assert property (@(posedge clk) disable iff (rst)
    pop && !push |=> count == CNT_W'($past(count) - 1'b1))
    else $error("queue count missed a pop");

endmodule

`default_nettype wire

FILE: design/rfidhex_back.sv
// Frame assembler: pairs digits into bytes, tracks the checksum and holds the
// result in an output register. Depends on rfidhex_pkg.
`default_nettype none

module rfidhex_back (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  rfidhex_pkg::token_t       tok,
  input  wire logic                 tok_valid,
  output logic                      tok_ready,
  output logic [39:0]               tag_code,
  output logic [7:0]                received_checksum,
  output logic                      checksum_ok,
  output logic                      out_valid,
  input  wire logic                 out_ready
);
  import rfidhex_pkg::*;

  localparam logic [DIGIT_CNT_W-1:0] LAST_DIGIT = DIGIT_CNT_W'(FRAME_DIGITS - 1);

  typedef enum logic {
    ST_IDLE,
    ST_FRAME
  } state_t;

  state_t                  state;
  logic [DIGIT_CNT_W-1:0]  digit_count;
  logic [NIBBLE_W-1:0]     pending_high;
  logic [TAG_W-1:0]        code_bytes;
  logic [BYTE_W-1:0]       running_xor;
  logic [BYTE_W-1:0]       pair;
  logic                    pop;
  logic                    fire;

  assign tok_ready = !out_valid || out_ready;
  assign pop       = tok_valid && tok_ready;
  assign pair      = {pending_high, {NIBBLE_W{1'b0}}} | tok.value;
  // checksum digit of an open frame: the result register loads this cycle
  assign fire      = pop && (state == ST_FRAME) && (tok.kind == TOK_DIGIT) &&
                     (digit_count == LAST_DIGIT);

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      digit_count <= '0;
      out_valid   <= 1'b0;
    end else begin
      if (fire) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      if (pop) begin
        unique case (state)
          ST_IDLE: begin
            if (tok.kind == TOK_START) begin
              state        <= ST_FRAME;
              digit_count  <= '0;
              pending_high <= '0;
              code_bytes   <= '0;
              running_xor  <= '0;
            end
          end
          ST_FRAME: begin
            unique case (tok.kind)
              TOK_START, TOK_ABORT: begin
                state       <= ST_IDLE;
                digit_count <= '0;
              end
              TOK_DIGIT: begin
                if (!digit_count[0]) begin
                  pending_high <= tok.value[NIBBLE_W-1:0];
                  digit_count  <= digit_count + 1'b1;
                end else if (digit_count == LAST_DIGIT) begin
                  tag_code          <= code_bytes;
                  received_checksum <= pair;
                  checksum_ok       <= (running_xor == pair);
                  state             <= ST_IDLE;
                  digit_count       <= '0;
                end else begin
                  code_bytes  <= {code_bytes[TAG_W-BYTE_W-1:0], pair};
                  running_xor <= running_xor ^ pair;
                  digit_count <= digit_count + 1'b1;
                end
              end
              default: begin
                state       <= ST_IDLE;
                digit_count <= '0;
              end
            endcase
          end
          default: begin
            state       <= ST_IDLE;
            digit_count <= '0;
          end
        endcase
      end
    end
  end

  a_idle_count: assert property (@(posedge clk) disable iff (rst)
    state == ST_IDLE |-> digit_count == '0)
    else $error("digit count not cleared in idle");

  a_count_range: assert property (@(posedge clk) disable iff (rst)
    digit_count <= LAST_DIGIT)
    else $error("digit count past end of frame");

  a_result_ends_frame: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state) == ST_FRAME && state == ST_IDLE)
    else $error("result without a completed frame");

endmodule

`default_nettype wire
